// File: hw/rtl/sef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_pkg
// Shared types and constants of the scan line even-odd fill block.
// ----------------------------------------------------------------------------
package sef_pkg;

    localparam int ROW_LEN_DEF = 64;
    localparam int COORD_W     = 12;

    typedef struct packed {
        logic [COORD_W-1:0] row_coord;
        logic               is_boundary;
        logic               is_prefilled;
        logic               last_in_row;
    } pix_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic               last_fill;
    } fill_word_t;

    typedef struct packed {
        logic boundary;
        logic filled;
    } sef_bit_t;

endpackage

// File: hw/rtl/sef_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_if
// Valid/ready channels of the fill block: pixel words in, fill words out.
// ----------------------------------------------------------------------------
interface sef_pix_if;
    logic                  valid;
    logic                  ready;
    sef_pkg::pix_word_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sef_fill_if;
    logic                  valid;
    logic                  ready;
    sef_pkg::fill_word_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sef_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sef_cell
// One position of the row shift chain: holds boundary and filled bits.
// ----------------------------------------------------------------------------
module sef_cell (
    input  logic              clk,
    input  logic              en,
    input  sef_pkg::sef_bit_t d,
    output sef_pkg::sef_bit_t q
);

    sef_pkg::sef_bit_t bit_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bit_reg <= d;
        end
    end

    assign q = bit_reg;

endmodule

// File: hw/rtl/scanline_even_odd_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_even_odd_fill
// Stores one scan line in a shift chain of cells, then shifts it out in
// position order and emits every point that lies inside by even-odd rule and is not prefilled.
// ----------------------------------------------------------------------------
//  channel   dir  word
//  pix       in   row_coord, is_boundary, is_prefilled, last_in_row
//  fill      out  x_coord, y_coord, last_fill
//  cfg       in   axis_swap (cfg_we / cfg_data)
//
//  Load: one pixel per cycle. On last_in_row the chain is shifted out in the
//  scan state, then the flush state follows; pix.ready is low meanwhile.
//  A stall on fill holds the shift chain.
//  Reset clears control state and axis_swap; the chain needs no clearing.
// ----------------------------------------------------------------------------
module scanline_even_odd_fill #(
    parameter int ROW_LEN = sef_pkg::ROW_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    sef_pix_if.sink    pix,
    sef_fill_if.source fill
);

    localparam int PW = $clog2(ROW_LEN);
    localparam int CW = $clog2(ROW_LEN + 1);
    localparam int CRD = sef_pkg::COORD_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    sef_pkg::sef_bit_t chain_d [ROW_LEN];
    sef_pkg::sef_bit_t chain_q [ROW_LEN];
    logic              chain_en;

    logic [1:0]     state_reg, state_next;
    logic           swap_reg;
    logic [CRD-1:0] row_reg, row_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [PW-1:0]  t_reg, t_next;
    logic           tot_reg, tot_next;
    logic           lprev_reg, lprev_next;
    logic           sprev_reg, sprev_next;
    logic           lpar_reg, lpar_next;
    logic           spar_reg, spar_next;
    logic           pend_reg, pend_next;
    logic [PW-1:0]  ppos_reg, ppos_next;
    logic           oval_reg, oval_next;
    sef_pkg::fill_word_t oword_reg, oword_next;

    logic           accept, store, out_free, pos_ok, emit, st_inc;
    logic           hb, hf, nb;
    logic [CW:0]    pos_sum;
    logic [PW-1:0]  pos_j;

    genvar k;
    generate
        for (k = 0; k < ROW_LEN; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign chain_d[k] = store ? sef_pkg::sef_bit_t'({pix.data.is_boundary,
                                                                 pix.data.is_prefilled})
                                          : sef_pkg::sef_bit_t'('0);
            end
            else
            begin : g_link
                assign chain_d[k] = chain_q[k-1];
            end
            sef_cell u_cell (
                .clk (clk),
                .en  (chain_en),
                .d   (chain_d[k]),
                .q   (chain_q[k])
            );
        end
    endgenerate

    assign pix.ready  = (state_reg == ST_IDLE);
    assign accept     = pix.valid && pix.ready;
    assign store      = accept && (cnt_reg < CW'(ROW_LEN));
    assign out_free   = !oval_reg || fill.ready;
    assign chain_en   = store || ((state_reg == ST_SCAN) && out_free);
    assign fill.valid = oval_reg;
    assign fill.data  = oword_reg;

    assign hb = chain_q[ROW_LEN-1].boundary;
    assign hf = chain_q[ROW_LEN-1].filled;
    assign nb = chain_q[ROW_LEN-2].boundary;

    assign pos_sum = (CW+1)'(t_reg) + (CW+1)'(cnt_reg) - (CW+1)'(ROW_LEN);
    assign pos_ok  = !pos_sum[CW];
    assign pos_j   = pos_sum[PW-1:0];
    assign st_inc  = spar_reg ^ (hb & ~sprev_reg);
    assign emit    = pos_ok && !hf && lpar_reg && (tot_reg ^ st_inc);

    function automatic sef_pkg::fill_word_t make_word(input logic swap,
                                                      input logic [CRD-1:0] row,
                                                      input logic [PW-1:0] pos,
                                                      input logic last);
        sef_pkg::fill_word_t w;
        w.x_coord   = swap ? row : CRD'(pos);
        w.y_coord   = swap ? CRD'(pos) : row;
        w.last_fill = last;
        return w;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        t_next     = t_reg;
        tot_next   = tot_reg;
        lprev_next = lprev_reg;
        sprev_next = sprev_reg;
        lpar_next  = lpar_reg;
        spar_next  = spar_reg;
        pend_next  = pend_reg;
        ppos_next  = ppos_reg;
        oval_next  = oval_reg && !fill.ready;
        oword_next = oword_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_next = pix.data.row_coord;
                    if (store)
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        tot_next   = tot_reg ^ (pix.data.is_boundary & ~lprev_reg);
                        lprev_next = pix.data.is_boundary;
                    end
                    if (pix.data.last_in_row)
                    begin
                        state_next = ST_SCAN;
                        t_next     = '0;
                        lpar_next  = 1'b0;
                        spar_next  = 1'b0;
                        sprev_next = 1'b0;
                        pend_next  = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (pos_ok)
                    begin
                        spar_next  = st_inc;
                        sprev_next = hb;
                        lpar_next  = lpar_reg ^ (hb & ~nb);
                    end
                    if (emit)
                    begin
                        if (pend_reg)
                        begin
                            oval_next  = 1'b1;
                            oword_next = make_word(swap_reg, row_reg, ppos_reg, 1'b0);
                        end
                        pend_next = 1'b1;
                        ppos_next = pos_j;
                    end
                    t_next = t_reg + 1'b1;
                    if (t_reg == PW'(ROW_LEN - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    if (pend_reg)
                    begin
                        oval_next  = 1'b1;
                        oword_next = make_word(swap_reg, row_reg, ppos_reg, 1'b1);
                    end
                    pend_next  = 1'b0;
                    cnt_next   = '0;
                    tot_next   = 1'b0;
                    lprev_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            swap_reg  <= 1'b0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            t_reg     <= '0;
            tot_reg   <= 1'b0;
            lprev_reg <= 1'b0;
            sprev_reg <= 1'b0;
            lpar_reg  <= 1'b0;
            spar_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                swap_reg <= cfg_data;
            end
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            t_reg     <= t_next;
            tot_reg   <= tot_next;
            lprev_reg <= lprev_next;
            sprev_reg <= sprev_next;
            lpar_reg  <= lpar_next;
            spar_reg  <= spar_next;
            pend_reg  <= pend_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ppos_reg  <= ppos_next;
        oword_reg <= oword_next;
    end

endmodule

// File: verif/scanline_even_odd_fill_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_even_odd_fill_test
// Streams scan lines through the fill block and checks every fill word
// against an even-odd predictor. Covers short directed rows, random rows of
// several shapes, full and over-long rows, both axis orders and idle bursts
// on both channels.
// ----------------------------------------------------------------------------
module scanline_even_odd_fill_test;

    localparam int ROW_LEN = sef_pkg::ROW_LEN_DEF;

    typedef enum int {ROW_SPARSE, ROW_RUNS, ROW_DENSE, ROW_EMPTY} row_shape_t;

    class fill_tracker;
        bit                         axis_swap;
        bit                         bnd_map [ROW_LEN];
        bit                         pre_map [ROW_LEN];
        int                         next_pos;
        logic [sef_pkg::COORD_W-1:0] row_val;
        sef_pkg::fill_word_t        pending_fills[$];
        int                         failures;
        int                         pixels_seen;
        int                         rows_done;
        int                         words_checked;

        function void report(string what, sef_pkg::fill_word_t want,
                             sef_pkg::fill_word_t got);
            failures++;
            if (failures <= 10)
                $display("%0t %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                         $time, what, want.x_coord, want.y_coord, want.last_fill,
                         got.x_coord, got.y_coord, got.last_fill);
        endfunction

        function void note_pixel(sef_pkg::pix_word_t w);
            bit                  starts [ROW_LEN];
            bit                  ends   [ROW_LEN];
            sef_pkg::fill_word_t found[$];
            sef_pkg::fill_word_t f;
            int                  lo;
            int                  hi;
            int                  left;
            int                  right;
            pixels_seen++;
            row_val = w.row_coord;
            if (next_pos < ROW_LEN)
            begin
                bnd_map[next_pos] = w.is_boundary;
                pre_map[next_pos] = w.is_prefilled;
                next_pos++;
            end
            if (!w.last_in_row)
                return;
            rows_done++;
            lo = -1;
            hi = -1;
            for (int i = 0; i < next_pos; i++)
            begin
                starts[i] = bnd_map[i] && (i == 0 || !bnd_map[i-1]);
                ends[i]   = bnd_map[i] && (i + 1 >= next_pos || !bnd_map[i+1]);
                if (bnd_map[i])
                begin
                    if (lo < 0)
                        lo = i;
                    hi = i;
                end
            end
            if (lo >= 0)
            begin
                for (int p = lo; p < hi; p++)
                begin
                    if (pre_map[p])
                        continue;
                    left  = 0;
                    right = 0;
                    for (int i = 0; i < next_pos; i++)
                    begin
                        if (ends[i] && i < p)
                            left++;
                        if (starts[i] && i > p)
                            right++;
                    end
                    if ((left % 2) == 1 && (right % 2) == 1)
                    begin
                        f.x_coord   = axis_swap ? row_val : sef_pkg::COORD_W'(p);
                        f.y_coord   = axis_swap ? sef_pkg::COORD_W'(p) : row_val;
                        f.last_fill = 1'b0;
                        found = {found, f};
                    end
                end
            end
            if (found.size() > 0)
                found[found.size()-1].last_fill = 1'b1;
            foreach (found[k])
                pending_fills = {pending_fills, found[k]};
            next_pos = 0;
        endfunction

        function void check_fill(sef_pkg::fill_word_t got);
            sef_pkg::fill_word_t want;
            words_checked++;
            if (pending_fills.size() == 0)
            begin
                report("unexpected fill word", '0, got);
                return;
            end
            want = pending_fills.pop_front();
            if (got.x_coord !== want.x_coord || got.y_coord !== want.y_coord ||
                got.last_fill !== want.last_fill)
                report("fill word mismatch", want, got);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;
    bit   source_gaps;
    bit   sink_stalls;
    int   drain_cycles;

    fill_tracker tracker = new();

    sef_pix_if  pix_ch ();
    sef_fill_if fill_ch ();

    scanline_even_odd_fill uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .pix      (pix_ch),
        .fill     (fill_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("scanline_even_odd_fill verification failed");
        $finish;
    end

    // fill side: random ready bursts
    initial
    begin
        fill_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                fill_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            fill_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && fill_ch.valid && fill_ch.ready)
            tracker.check_fill(fill_ch.data);
    end

    task automatic send_pixel(input sef_pkg::pix_word_t w);
        @(negedge clk);
        if (source_gaps && $urandom_range(0, 5) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= w;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        tracker.note_pixel(w);
    endtask

    task automatic send_fixed(input int len, input logic [ROW_LEN-1:0] bnd,
                              input logic [ROW_LEN-1:0] pre,
                              input logic [sef_pkg::COORD_W-1:0] row, input bit mixed);
        sef_pkg::pix_word_t w;
        for (int i = 0; i < len; i++)
        begin
            w.is_boundary  = (i < ROW_LEN) ? bnd[i] : 1'($urandom_range(0, 1));
            w.is_prefilled = (i < ROW_LEN) ? pre[i] : 1'($urandom_range(0, 1));
            w.last_in_row  = (i == len - 1);
            w.row_coord    = (mixed && i != len - 1) ? sef_pkg::COORD_W'($urandom) : row;
            send_pixel(w);
        end
    endtask

    task automatic send_row(input int len, input row_shape_t shape,
                            input logic [sef_pkg::COORD_W-1:0] row);
        logic [ROW_LEN-1:0] bnd;
        logic [ROW_LEN-1:0] pre;
        bit                 in_run;
        int                 span_left;
        in_run    = 1'($urandom_range(0, 1));
        span_left = 0;
        for (int i = 0; i < ROW_LEN; i++)
        begin
            case (shape)
                ROW_SPARSE: bnd[i] = ($urandom_range(0, 5) == 0);
                ROW_RUNS:
                begin
                    if (span_left == 0)
                    begin
                        in_run    = !in_run;
                        span_left = in_run ? int'($urandom_range(1, 3))
                                           : int'($urandom_range(1, 7));
                    end
                    bnd[i] = in_run;
                    span_left--;
                end
                ROW_DENSE: bnd[i] = 1'($urandom_range(0, 1));
                default:   bnd[i] = 1'b0;
            endcase
            pre[i] = ($urandom_range(0, 7) == 0);
        end
        send_fixed(len, bnd, pre, row, $urandom_range(0, 9) == 0);
    endtask

    task automatic run_rows(input int items);
        int         sent;
        int         len;
        int         pick;
        row_shape_t shape;
        sent = 0;
        while (sent < items)
        begin
            pick = int'($urandom_range(0, 19));
            if (pick == 0)
                len = ROW_LEN;
            else if (pick == 1)
                len = int'($urandom_range(ROW_LEN + 1, ROW_LEN + 8));
            else if (pick == 2)
                len = int'($urandom_range(1, 3));
            else
                len = int'($urandom_range(4, 20));
            pick = int'($urandom_range(0, 9));
            if (pick < 6)
                shape = ROW_RUNS;
            else if (pick < 8)
                shape = ROW_SPARSE;
            else if (pick < 9)
                shape = ROW_DENSE;
            else
                shape = ROW_EMPTY;
            send_row(len, shape, sef_pkg::COORD_W'($urandom));
            sent += len;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
        while (tracker.pending_fills.size() != 0)
            @(posedge clk);
    endtask

    // scan keeps running after the last fill word, wait it out before cfg
    task automatic write_axis_swap(input bit v);
        drain();
        repeat (ROW_LEN + 8) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        tracker.axis_swap = v;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_data     <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.data  <= '0;
        source_gaps  = 1'b1;
        sink_stalls  = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_axis_swap(1'b0);
        // single pixel, lone boundary
        send_fixed(1, 64'h1, 64'h0, 12'd0, 1'b0);
        // two gap points, one of them prefilled
        send_fixed(4, 64'h9, 64'h4, 12'd4095, 1'b0);
        // no boundary at all, coord varies
        send_fixed(3, 64'h0, 64'h7, 12'd2730, 1'b1);
        // wide runs and a single-pixel run
        send_fixed(8, 64'hB3, 64'h0, 12'd1365, 1'b0);
        // alternating boundaries
        send_fixed(7, 64'h55, 64'h0, 12'd0, 1'b0);

        write_axis_swap(1'b1);
        send_fixed(ROW_LEN, {1'b1, {(ROW_LEN-2){1'b0}}, 1'b1}, '0, 12'd4095, 1'b0);
        run_rows(30);
        drain();
        run_rows(30);

        write_axis_swap(1'b0);
        send_row(ROW_LEN + 6, ROW_RUNS, 12'd2048);
        run_rows(60);

        write_axis_swap(1'b1);
        drain();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        run_rows(100);

        drain_cycles = 0;
        @(negedge clk);
        pix_ch.valid <= 1'b0;
        while (tracker.pending_fills.size() != 0 && drain_cycles < 50000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (ROW_LEN + 8) @(posedge clk);
        if (tracker.pending_fills.size() != 0)
        begin
            $display("%0d fill words never arrived", tracker.pending_fills.size());
            tracker.failures += tracker.pending_fills.size();
        end

        $display("%0d rows, %0d pixel words, %0d fill words checked, %0d mismatches",
                 tracker.rows_done, tracker.pixels_seen, tracker.words_checked,
                 tracker.failures);
        $display("both axis orders, full and over-long rows, idle bursts on both sides");
        if (tracker.failures == 0)
            $display("scanline_even_odd_fill verification clean");
        else
            $display("scanline_even_odd_fill verification failed");
        $finish;
    end

endmodule
